FILE: sv/frb_pkg.sv
package frb_pkg;

    localparam int TS_W       = 32;
    localparam int ORD_W      = 32;
    localparam int TAG_PORT_W = 8;
    localparam int HOLD_W     = 5;
    localparam int OCC_W      = 5;
    localparam int SIZE_W     = 16;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 5'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // per-beat control for the candidate tracker
    typedef struct packed {
        logic valid;   // read data is a held entry
        logic first;   // entry 0: load unconditionally
    } pick_ctl_t;

    // a is strictly earlier than b: by timestamp when both have one, else by decode order
    function automatic logic strictly_earlier(
        input logic [TS_W-1:0]  ts_a,
        input logic [ORD_W-1:0] ord_a,
        input logic [TS_W-1:0]  ts_b,
        input logic [ORD_W-1:0] ord_b
    );
        logic both_timed;
        both_timed = !ts_a[TS_W-1] && !ts_b[TS_W-1];
        if (both_timed)
            return ts_a < ts_b;
        return ord_a < ord_b;
    endfunction

endpackage

FILE: sv/frb_ram.sv
module frb_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/frb_pick.sv
module frb_pick #(
    parameter int IDX_W = 4,
    parameter int TAG_W = 8
) (
    input  logic                         clk,
    input  frb_pkg::pick_ctl_t           ctl,
    input  logic [IDX_W-1:0]             idx,
    input  logic [frb_pkg::TS_W-1:0]     ts,
    input  logic [frb_pkg::ORD_W-1:0]    ord,
    input  logic [TAG_W-1:0]             tag,
    output logic [IDX_W-1:0]             best_idx,
    output logic [frb_pkg::TS_W-1:0]     best_ts,
    output logic [TAG_W-1:0]             best_tag
);

    logic [IDX_W-1:0]          best_idx_reg;
    logic [frb_pkg::TS_W-1:0]  best_ts_reg;
    logic [frb_pkg::ORD_W-1:0] best_ord_reg;
    logic [TAG_W-1:0]          best_tag_reg;
    logic                      take;

    // later entry replaces the candidate only when strictly earlier
    assign take = ctl.valid &&
                  (ctl.first ||
                   frb_pkg::strictly_earlier(ts, ord, best_ts_reg, best_ord_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= idx;
            best_ts_reg  <= ts;
            best_ord_reg <= ord;
            best_tag_reg <= tag;
        end
    end

    assign best_idx = best_idx_reg;
    assign best_ts  = best_ts_reg;
    assign best_tag = best_tag_reg;

endmodule

FILE: sv/frame_reorder_buffer.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+---------------------------------------------
// command   | start, busy             | operation, frame_present, frame_tag,
//           |  (beat: start && !busy) | timestamp, decode_order, width_in,
//           |                         | height_in, flush
// result    | done (one-cycle strobe) | popped, out_tag, out_timestamp, dropped,
//           |                         | occupancy, frame_width, frame_height
// config    | hold_depth_we           | hold_depth_wdata
//
// Insert, ignored insert, dropped insert and a pop that releases nothing:
// result strobe on the cycle after the command beat, busy stays low.
// Releasing pop: strobe after ST_SCAN over all held entries, ST_WAIT, ST_SEEK and
// ST_MOVE over the entries above the candidate slot, a sequence set by the single
// read port of the slot memory, used first for the scan, then for close-up.
// Reset clears control, count, hold depth (to 4) and frame size; slots are
// not cleared, only data read from held slots is ever used.
// The receiver cannot stall: each result is shown for exactly one cycle.
module frame_reorder_buffer #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic                                frame_present,
    input  logic [frb_pkg::TAG_PORT_W-1:0]      frame_tag,
    input  logic signed [frb_pkg::TS_W-1:0]     timestamp,
    input  logic [frb_pkg::ORD_W-1:0]           decode_order,
    input  logic [frb_pkg::SIZE_W-1:0]          width_in,
    input  logic [frb_pkg::SIZE_W-1:0]          height_in,
    input  logic                                flush,
    input  logic                                hold_depth_we,
    input  logic [frb_pkg::HOLD_W-1:0]          hold_depth_wdata,
    output logic                                done,
    output logic                                popped,
    output logic [frb_pkg::TAG_PORT_W-1:0]      out_tag,
    output logic signed [frb_pkg::TS_W-1:0]     out_timestamp,
    output logic                                dropped,
    output logic [frb_pkg::OCC_W-1:0]           occupancy,
    output logic [frb_pkg::SIZE_W-1:0]          frame_width,
    output logic [frb_pkg::SIZE_W-1:0]          frame_height
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_W = (TAG_BITS < frb_pkg::TAG_PORT_W) ? TAG_BITS : frb_pkg::TAG_PORT_W;
    localparam int ENTRY_W = frb_pkg::TS_W + frb_pkg::ORD_W + STORE_W;
    localparam int CMP_W   = (CNT_W > frb_pkg::HOLD_W) ? CNT_W : frb_pkg::HOLD_W;
    localparam int WIDE_W  = (CMP_W > frb_pkg::OCC_W) ? CMP_W : frb_pkg::OCC_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;   // issue slot reads in arrival order
    localparam logic [2:0] ST_WAIT = 3'd2;   // last read data reaches the tracker
    localparam logic [2:0] ST_SEEK = 3'd3;   // start close-up at the winner
    localparam logic [2:0] ST_MOVE = 3'd4;   // read slot i+1, write it to slot i

    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic [CNT_W-1:0]             scan_k_reg, scan_k_next;
    logic [CNT_W-1:0]             mv_idx_reg, mv_idx_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]             wr_addr_reg, wr_addr_next;
    logic [frb_pkg::HOLD_W-1:0]   hold_reg, hold_next;
    logic [frb_pkg::SIZE_W-1:0]   lw_reg, lw_next;
    logic [frb_pkg::SIZE_W-1:0]   lh_reg, lh_next;
    logic                         done_reg, done_next;
    logic                         popped_reg, popped_next;
    logic [frb_pkg::TAG_PORT_W-1:0] tag_reg, tag_next;
    logic [frb_pkg::TS_W-1:0]     ts_reg, ts_next;
    logic                         dropped_reg, dropped_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]           ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ENTRY_W-1:0]           ram_rdata;

    frb_pkg::pick_ctl_t           pick_ctl;
    logic [IDX_W-1:0]             best_idx;
    logic [frb_pkg::TS_W-1:0]     best_ts;
    logic [STORE_W-1:0]           best_tag;

    logic [CNT_W-1:0]             mv_plus;
    logic                         can_release;
    logic [WIDE_W-1:0]            count_wide;

    // slot memory, entry = {timestamp, decode order, tag}
    frb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pick_ctl.valid = rd_pend_reg;
    assign pick_ctl.first = (rd_idx_reg == '0);

    frb_pick #(
        .IDX_W (IDX_W),
        .TAG_W (STORE_W)
    ) u_pick (
        .clk      (clk),
        .ctl      (pick_ctl),
        .idx      (rd_idx_reg[IDX_W-1:0]),
        .ts       (ram_rdata[ENTRY_W-1 -: frb_pkg::TS_W]),
        .ord      (ram_rdata[STORE_W +: frb_pkg::ORD_W]),
        .tag      (ram_rdata[STORE_W-1:0]),
        .best_idx (best_idx),
        .best_ts  (best_ts),
        .best_tag (best_tag)
    );

    assign mv_plus     = mv_idx_reg + 1'b1;
    assign can_release = (count_reg != '0) &&
                         (flush || (CMP_W'(count_reg) >= CMP_W'(hold_reg)));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        scan_k_next  = scan_k_reg;
        mv_idx_next  = mv_idx_reg;
        rd_pend_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        hold_next    = hold_reg;
        lw_next      = lw_reg;
        lh_next      = lh_reg;
        done_next    = 1'b0;
        popped_next  = popped_reg;
        tag_next     = tag_reg;
        ts_next      = ts_reg;
        dropped_next = dropped_reg;

        // close-up write lands in the cycle after its read
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = scan_k_reg[IDX_W-1:0];

        if (hold_depth_we)
        begin
            hold_next = hold_depth_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    popped_next  = 1'b0;
                    tag_next     = '0;
                    ts_next      = '0;
                    dropped_next = 1'b0;
                    if (operation == frb_pkg::OP_INSERT)
                    begin
                        done_next = 1'b1;
                        if (frame_present)
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[IDX_W-1:0];
                                ram_wdata  = {timestamp, decode_order, frame_tag[STORE_W-1:0]};
                                count_next = count_reg + 1'b1;
                                lw_next    = width_in;
                                lh_next    = height_in;
                            end
                        end
                    end
                    else if (can_release)
                    begin
                        n_next      = count_reg;
                        scan_k_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_raddr    = scan_k_reg[IDX_W-1:0];
                rd_pend_next = 1'b1;
                rd_idx_next  = scan_k_reg;
                scan_k_next  = scan_k_reg + 1'b1;
                if (scan_k_reg == n_reg - 1'b1)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_SEEK;
            end
            ST_SEEK:
            begin
                mv_idx_next = CNT_W'(best_idx);
                state_next  = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (mv_plus < n_reg)
                begin
                    ram_raddr    = mv_plus[IDX_W-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = mv_idx_reg[IDX_W-1:0];
                    mv_idx_next  = mv_plus;
                end
                else
                begin
                    done_next   = 1'b1;
                    popped_next = 1'b1;
                    tag_next    = frb_pkg::TAG_PORT_W'(best_tag);
                    ts_next     = best_ts;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            hold_reg    <= frb_pkg::HOLD_RESET;
            lw_reg      <= '0;
            lh_reg      <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            wr_pend_reg <= wr_pend_next;
            hold_reg    <= hold_next;
            lw_reg      <= lw_next;
            lh_reg      <= lh_next;
            done_reg    <= done_next;
        end
    end

    // payload and loop registers
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        scan_k_reg  <= scan_k_next;
        mv_idx_reg  <= mv_idx_next;
        rd_idx_reg  <= rd_idx_next;
        wr_addr_reg <= wr_addr_next;
        popped_reg  <= popped_next;
        tag_reg     <= tag_next;
        ts_reg      <= ts_next;
        dropped_reg <= dropped_next;
    end

    assign count_wide    = WIDE_W'(count_reg);
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign popped        = popped_reg;
    assign out_tag       = tag_reg;
    assign out_timestamp = ts_reg;
    assign dropped       = dropped_reg;
    assign occupancy     = count_wide[frb_pkg::OCC_W-1:0];
    assign frame_width   = lw_reg;
    assign frame_height  = lh_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("held count above queue depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while sequencer busy");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && popped_reg) |-> (count_reg == $past(count_reg) - 1'b1))
        else $error("released beat did not remove one entry");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_k_reg < n_reg))
        else $error("scan read beyond held entries");

    a_move_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> ((CNT_W'(wr_addr_reg) + 1'b1 < n_reg) && (state_reg == ST_MOVE)))
        else $error("close-up write outside held range");

endmodule
